// ===== hdl/kwm_pkg.sv =====
// shared types and codes for the k-way sorted list merge
package kwm_pkg;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_TAKE   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [2:0]         sel;
        logic signed [31:0] value;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SCAN,
        BS_LAST,
        BS_DONE
    } t_bstate;

endpackage

// ===== hdl/kwm_ram.sv =====
// generic single-write, single-read ram with registered read data
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/kwm_front.sv =====
// front end: accepts words, drops unused opcodes, queues commands
module kwm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic [2:0]         i_list_select,
    input  logic signed [31:0] i_value,
    output logic               o_q_valid,
    output kwm_pkg::t_cmd      o_q_cmd,
    input  logic               i_q_pop
);
    kwm_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_push;
    kwm_pkg::t_cmd w_cmd;

    assign o_stall = (r_cnt == 2'd2);
    assign w_cmd.op    = kwm_pkg::t_op'(i_opcode);
    assign w_cmd.sel   = i_list_select;
    assign w_cmd.value = i_value;
    // unused opcode is accepted and forgotten
    assign w_push = i_valid && !o_stall && (w_cmd.op != kwm_pkg::OP_NOP);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_mem[r_rp];
endmodule

// ===== hdl/kwm_back.sv =====
// back end: list counters, head scan and the result register
module kwm_back #(
    parameter int NUM_LISTS  = 8,
    parameter int LIST_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  kwm_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    output logic               o_ram_we,
    output logic [(NUM_LISTS*LIST_DEPTH > 1 ? $clog2(NUM_LISTS*LIST_DEPTH) : 1)-1:0] o_ram_waddr,
    output logic [31:0]        o_ram_wdata,
    output logic [(NUM_LISTS*LIST_DEPTH > 1 ? $clog2(NUM_LISTS*LIST_DEPTH) : 1)-1:0] o_ram_raddr,
    input  logic [31:0]        i_ram_rdata,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_merged_value,
    output logic [2:0]         o_source_list
);
    localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = (NUM_LISTS*LIST_DEPTH > 1) ? $clog2(NUM_LISTS*LIST_DEPTH) : 1;

    kwm_pkg::t_bstate   r_state, n_state;
    logic [CW-1:0]      r_fill [NUM_LISTS];
    logic [CW-1:0]      r_take [NUM_LISTS];
    logic [LW-1:0]      r_idx;
    logic               r_pend;
    logic [LW-1:0]      r_pidx;
    logic               r_found;
    logic [LW-1:0]      r_best_idx;
    logic signed [31:0] r_best_val;
    logic               r_ovalid;
    kwm_pkg::t_status   r_status;
    logic signed [31:0] r_val;
    logic [2:0]         r_src;

    logic          w_out_free;
    logic [LW-1:0] w_idx;
    logic [CW-1:0] w_fill;
    logic [CW-1:0] w_take;
    logic          w_bad_sel;
    logic          w_app_ok;
    logic          w_app_full;
    logic          w_start_take;
    logic          w_clear;
    logic          w_issue;
    logic          w_emit;

    assign w_out_free = !r_ovalid || !i_stall;
    assign o_q_pop    = (r_state == kwm_pkg::BS_IDLE) && i_q_valid && w_out_free;
    assign w_idx      = (r_state == kwm_pkg::BS_IDLE) ? LW'(i_q_cmd.sel) : r_idx;
    assign w_fill     = r_fill[w_idx];
    assign w_take     = r_take[w_idx];
    assign w_bad_sel  = (32'(i_q_cmd.sel) >= 32'(NUM_LISTS));

    assign w_app_ok     = o_q_pop && (i_q_cmd.op == kwm_pkg::OP_APPEND) && !w_bad_sel
                          && (w_fill < CW'(LIST_DEPTH));
    assign w_app_full   = o_q_pop && (i_q_cmd.op == kwm_pkg::OP_APPEND) && !w_app_ok;
    assign w_start_take = o_q_pop && (i_q_cmd.op == kwm_pkg::OP_TAKE);
    assign w_clear      = o_q_pop && (i_q_cmd.op == kwm_pkg::OP_CLEAR);
    assign w_issue      = (r_state == kwm_pkg::BS_SCAN) && (w_take < w_fill);
    assign w_emit       = (r_state == kwm_pkg::BS_DONE);

    assign o_ram_we    = w_app_ok;
    assign o_ram_waddr = AW'(AW'(w_idx) * AW'(LIST_DEPTH) + AW'(w_fill));
    assign o_ram_wdata = i_q_cmd.value;
    assign o_ram_raddr = AW'(AW'(w_idx) * AW'(LIST_DEPTH) + AW'(w_take));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kwm_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kwm_pkg::BS_IDLE: begin
                if (w_start_take) begin
                    n_state = kwm_pkg::BS_SCAN;
                end
            end
            kwm_pkg::BS_SCAN: begin
                if (r_idx == LW'(NUM_LISTS - 1)) begin
                    n_state = kwm_pkg::BS_LAST;
                end
            end
            kwm_pkg::BS_LAST: n_state = kwm_pkg::BS_DONE;
            kwm_pkg::BS_DONE: n_state = kwm_pkg::BS_IDLE;
            default:          n_state = kwm_pkg::BS_IDLE;
        endcase
    end

    // per-list counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            for (int k = 0; k < NUM_LISTS; k++) begin
                r_fill[k] <= '0;
                r_take[k] <= '0;
            end
        end else begin
            if (w_app_ok) begin
                r_fill[w_idx] <= w_fill + CW'(1);
            end
            if (w_emit && r_found) begin
                r_take[r_best_idx] <= r_take[r_best_idx] + CW'(1);
            end
        end
    end

    // head scan, one list per cycle, compare in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_pend <= w_issue;
            r_pidx <= r_idx;
            if (w_start_take) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (r_state == kwm_pkg::BS_SCAN) begin
                r_idx <= r_idx + LW'(1);
            end
            if (r_pend && (!r_found || $signed(i_ram_rdata) <= r_best_val)) begin
                r_found    <= 1'b1;
                r_best_idx <= r_pidx;
                r_best_val <= $signed(i_ram_rdata);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_app_full) begin
            r_ovalid <= 1'b1;
            r_status <= kwm_pkg::ST_FULL;
            r_val    <= '0;
            r_src    <= i_q_cmd.sel;
        end else if (w_emit) begin
            r_ovalid <= 1'b1;
            r_status <= r_found ? kwm_pkg::ST_OK : kwm_pkg::ST_EMPTY;
            r_val    <= r_found ? r_best_val : '0;
            r_src    <= r_found ? 3'(r_best_idx) : 3'd0;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_merged_value = r_val;
    assign o_source_list  = r_src;
endmodule

// ===== hdl/k_way_sorted_list_merge.sv =====
// top level of the k-way sorted list merge
//
//  channel | valid   | stall   | fields
//  --------+---------+---------+------------------------------------------
//  in      | i_valid | o_stall | i_opcode, i_list_select, i_value
//  out     | o_valid | i_stall | o_status, o_merged_value, o_source_list
//
// an append or clear completes in the idle state; a take steps through scan, last and done,
// and the head scan reads one list head per cycle from the single list ram
// a two-word command queue sits between front and back, so up to two words are accepted
// while the back end scans or while a result waits in the output register
// reset is synchronous and active low; it empties every list, no ram sweep
// the back end only starts a command when the output register is free
module k_way_sorted_list_merge #(
    parameter int NUM_LISTS  = 8,
    parameter int LIST_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic [2:0]         i_list_select,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_merged_value,
    output logic [2:0]         o_source_list
);
    // list k lives at ram words k*LIST_DEPTH .. k*LIST_DEPTH+LIST_DEPTH-1
    localparam int RAM_DEPTH = NUM_LISTS * LIST_DEPTH;
    localparam int AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    // queue between front and back
    logic          w_q_valid;
    kwm_pkg::t_cmd w_q_cmd;
    logic          w_q_pop;

    // list ram
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [31:0]   w_ram_wdata;
    logic [AW-1:0] w_ram_raddr;
    logic [31:0]   w_ram_rdata;

    kwm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_list_select (i_list_select),
        .i_value       (i_value),
        .o_q_valid     (w_q_valid),
        .o_q_cmd       (w_q_cmd),
        .i_q_pop       (w_q_pop)
    );

    kwm_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    kwm_back #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_cmd        (w_q_cmd),
        .o_q_pop        (w_q_pop),
        .o_ram_we       (w_ram_we),
        .o_ram_waddr    (w_ram_waddr),
        .o_ram_wdata    (w_ram_wdata),
        .o_ram_raddr    (w_ram_raddr),
        .i_ram_rdata    (w_ram_rdata),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_merged_value (o_merged_value),
        .o_source_list  (o_source_list)
    );
endmodule

// ===== verif/tb.sv =====
// testbench for the k-way sorted list merge: directed and random commands against a built-in merge predictor
module tb;

    localparam int NLISTS = 8;
    localparam int DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_opcode;
    logic [2:0]         i_list_select;
    logic signed [31:0] i_value;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_status;
    logic signed [31:0] o_merged_value;
    logic [2:0]         o_source_list;

    typedef struct packed {
        kwm_pkg::t_status   status;
        logic signed [31:0] merged;
        logic [2:0]         src;
    } t_outcome;

    // predictor state: list contents and per-list fill and take counts
    logic signed [31:0] lists [NLISTS][DEPTH];
    int                 fills [NLISTS];
    int                 takes [NLISTS];

    kwm_pkg::t_cmd cmd_q [$];
    t_outcome      outcome_q [$];
    int       errors;
    int       sent;
    int       queued;
    int       idle_cycles;
    bit       stimulus_done;
    bit       calm;          // no idling in the last part of the run
    int       tx_gap;
    int       rx_gap;
    int       hold_off;      // long receiver hold-off counter
    int       watchdog;

    k_way_sorted_list_merge #(.NUM_LISTS(NLISTS), .LIST_DEPTH(DEPTH)) DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // append to the tail of the pending command queue
    function automatic void add_cmd(kwm_pkg::t_cmd c);
        cmd_q.insert(cmd_q.size(), c);
    endfunction

    // append to the tail of the expected word queue
    function automatic void add_outcome(t_outcome o);
        outcome_q.insert(outcome_q.size(), o);
    endfunction

    // predictor: apply one accepted word, queue any outcome it causes
    task automatic predict_word(input kwm_pkg::t_cmd c);
        int       best;
        t_outcome o;
        best = -1;
        case (c.op)
            kwm_pkg::OP_APPEND: begin
                if (c.sel >= NLISTS || fills[c.sel] >= DEPTH) begin
                    o.status = kwm_pkg::ST_FULL;
                    o.merged = '0;
                    o.src = c.sel;
                    add_outcome(o);
                end else begin
                    lists[c.sel][fills[c.sel]] = c.value;
                    fills[c.sel]++;
                end
            end
            kwm_pkg::OP_TAKE: begin
                // <= so the higher index wins ties
                for (int k = 0; k < NLISTS; k++) begin
                    if (takes[k] < fills[k]) begin
                        if (best < 0 || lists[k][takes[k]] <= lists[best][takes[best]])
                            best = k;
                    end
                end
                if (best < 0) begin
                    o.status = kwm_pkg::ST_EMPTY;
                    o.merged = '0;
                    o.src = '0;
                end else begin
                    o.status = kwm_pkg::ST_OK;
                    o.merged = lists[best][takes[best]];
                    o.src = best[2:0];
                    takes[best]++;
                end
                add_outcome(o);
            end
            kwm_pkg::OP_CLEAR: begin
                for (int k = 0; k < NLISTS; k++) begin
                    fills[k] = 0;
                    takes[k] = 0;
                end
            end
            default: ;
        endcase
    endtask

    function automatic kwm_pkg::t_cmd make_cmd(kwm_pkg::t_op op, int sel, logic [31:0] v);
        kwm_pkg::t_cmd c;
        c.op = op;
        c.sel = sel[2:0];
        c.value = v;
        return c;
    endfunction

    // non-decreasing run of appends to one list, starting at base
    task automatic push_run(int sel, int len, logic signed [31:0] base);
        logic signed [31:0] v;
        v = base;
        for (int j = 0; j < len; j++) begin
            add_cmd(make_cmd(kwm_pkg::OP_APPEND, sel, v));
            queued++;
            v = v + $signed({1'b0, 31'($urandom_range(0, 3))}) ;
        end
    endtask

    // stimulus
    initial begin
        int kind;
        errors = 0;
        queued = 0;
        calm = 1'b0;
        for (int k = 0; k < NLISTS; k++) begin
            fills[k] = 0;
            takes[k] = 0;
        end
        // directed: extremes, ties, empty take, full list, clear, unused opcode
        add_cmd(make_cmd(kwm_pkg::OP_TAKE, 0, 32'h0));
        add_cmd(make_cmd(kwm_pkg::OP_APPEND, 0, 32'h8000_0000));
        add_cmd(make_cmd(kwm_pkg::OP_APPEND, 0, 32'h7fff_ffff));
        add_cmd(make_cmd(kwm_pkg::OP_APPEND, 7, 32'h8000_0000));
        add_cmd(make_cmd(kwm_pkg::OP_APPEND, 3, 32'h0000_0000));
        add_cmd(make_cmd(kwm_pkg::OP_APPEND, 5, 32'hffff_ffff));
        add_cmd(make_cmd(kwm_pkg::OP_NOP, 7, 32'hffff_ffff));
        for (int j = 0; j < 6; j++) add_cmd(make_cmd(kwm_pkg::OP_TAKE, 0, 32'h0));
        add_cmd(make_cmd(kwm_pkg::OP_CLEAR, 0, 32'h0));
        add_cmd(make_cmd(kwm_pkg::OP_TAKE, 0, 32'h0));
        queued = cmd_q.size();
        push_run(2, DEPTH, -32'sd5);
        add_cmd(make_cmd(kwm_pkg::OP_APPEND, 2, 32'h1234_5678));
        add_cmd(make_cmd(kwm_pkg::OP_CLEAR, 0, 32'h0));
        queued += 2;
        // random: mostly non-decreasing runs and take bursts, some noise
        while (queued < 650) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                push_run($urandom_range(0, NLISTS - 1), $urandom_range(1, 8),
                         ($urandom_range(0, 3) == 0) ? $signed($urandom()) :
                         $signed(32'($urandom_range(0, 40)) - 32'sd20));
            end else if (kind < 8) begin
                for (int j = $urandom_range(1, 10); j > 0; j--) begin
                    add_cmd(make_cmd(kwm_pkg::OP_TAKE, $urandom_range(0, 7), $urandom()));
                    queued++;
                end
            end else if (kind == 8) begin
                add_cmd(make_cmd(kwm_pkg::t_op'($urandom_range(0, 3)),
                                 $urandom_range(0, 7), $urandom()));
                queued++;
            end else begin
                add_cmd(make_cmd(($urandom_range(0, 5) == 0) ? kwm_pkg::OP_CLEAR
                                                              : kwm_pkg::OP_APPEND,
                                 $urandom_range(0, 7), $urandom()));
                queued++;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver: offers the queue head, with random gaps on the sending side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_opcode <= kwm_pkg::OP_NOP;
            i_list_select <= '0;
            i_value <= '0;
            tx_gap <= 0;
            sent <= 0;
            stimulus_done <= 1'b0;
        end else begin
            kwm_pkg::t_cmd c;
            bit            busy;
            busy = i_valid && o_stall;
            if (i_valid && !o_stall) begin
                predict_word(make_cmd(kwm_pkg::t_op'(i_opcode), i_list_select, i_value));
                sent <= sent + 1;
                if (sent + 1 > queued - 60) calm <= 1'b1;
            end
            if (!busy) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        tx_gap <= $urandom_range(0, 3);
                        i_valid <= 1'b0;
                    end else begin
                        c = cmd_q.pop_front();
                        i_valid <= 1'b1;
                        i_opcode <= c.op;
                        i_list_select <= c.sel;
                        i_value <= c.value;
                    end
                end else begin
                    i_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_gap <= 0;
            hold_off <= 0;
        end else begin
            t_outcome e;
            if (o_valid && !i_stall) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected word status=%0d value=%0d src=%0d",
                             $time, o_status, o_merged_value, o_source_list);
                    errors++;
                end else begin
                    e = outcome_q.pop_front();
                    if (o_status !== e.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, o_status);
                        errors++;
                    end
                    if (o_merged_value !== e.merged) begin
                        $display("%0t: merged_value expected %0d actual %0d",
                                 $time, e.merged, o_merged_value);
                        errors++;
                    end
                    if (o_source_list !== e.src) begin
                        $display("%0t: source_list expected %0d actual %0d",
                                 $time, e.src, o_source_list);
                        errors++;
                    end
                end
            end
            // one long hold-off early in the random part fills the block
            if (sent >= 200 && sent < 210 && hold_off == 0) begin
                hold_off <= 1;
                i_stall <= 1'b1;
            end else if (hold_off > 0 && hold_off < 300) begin
                hold_off <= hold_off + 1;
                i_stall <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                rx_gap <= $urandom_range(0, 3);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            watchdog <= 0;
        end else begin
            watchdog <= watchdog + 1;
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // end of run: drain expectations, then a settle window for late words
    initial begin
        @(posedge i_rst_n);
        wait (stimulus_done && outcome_q.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && outcome_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
